// ===== rtl/rsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfb_pkg
// Shared types, constants and the CRC-8 helper for the RS-485 frame builder.
// ----------------------------------------------------------------------------
package rsfb_pkg;

	typedef logic [7:0] byte_t;

	// Default buffer size; the payload length saturates at this minus nine.
	localparam int BUF_BYTES_DEF = 128;

	// Largest number of bytes one input item can produce.
	localparam int BURST_LEN = 9;
	localparam int CNT_W     = $clog2(BURST_LEN + 1);

	// Input operation codes.
	localparam logic OP_BEGIN   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// Configuration register indexes.
	localparam int          REG_IDX_W   = 2;
	localparam logic [1:0]  REG_STATION = 2'd0;
	localparam logic [1:0]  REG_DEST    = 2'd1;
	localparam logic [1:0]  REG_TAIL_HI = 2'd2;
	localparam logic [1:0]  REG_TAIL_LO = 2'd3;

	// Start bytes for normal and idle frames.
	localparam byte_t SOF0_NORMAL = 8'hBB;
	localparam byte_t SOF1_NORMAL = 8'hEE;
	localparam byte_t SOF0_IDLE   = 8'hAA;
	localparam byte_t SOF1_IDLE   = 8'hFF;

	// Reflected Dallas/Maxim polynomial.
	localparam byte_t CRC_POLY = 8'h8C;

	// One byte of CRC-8, LSB first. This is a pure XOR network after synthesis.
	function automatic byte_t crc8_update(input byte_t crc, input byte_t b);
		byte_t c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/rs485_frame_builder_crc8_top.sv =====
// ----------------------------------------------------------------------------
// rs485_frame_builder_crc8_top
// Builds outgoing RS-485 link frames one byte per beat, with a CRC-8 trailer.
// ----------------------------------------------------------------------------
// An accepted item passes through the input register, then the output burst
// register, and its first byte shows once the output side is free.
// Throughput: one output byte per cycle while the receiver does not stall. An
// item that yields one byte lets the next item in every unstalled cycle; a
// larger item holds the input while the nine-byte output burst register shifts out.
// Reset: configuration registers, frame state and all valid flags clear at once.
// ----------------------------------------------------------------------------
module rs485_frame_builder_crc8_top
	import rsfb_pkg::*;
#(
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input item channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [7:0]           command,
	input  logic [6:0]           payload_length,
	input  logic                 idle_header,
	input  logic [7:0]           data_byte,
	// Result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           tx_byte,
	output logic                 frame_end,
	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam logic [7:0] MAX_PAY = 8'(BUF_BYTES - 9);

	// Configuration registers.
	byte_t station_q, dest_q, tail_hi_q, tail_lo_q;

	// Frame state.
	logic       open_q;
	logic [6:0] left_q;
	byte_t      crc_q;

	// Input register stage.
	logic       valid_s1;
	logic       op_s1;
	byte_t      cmd_s1;
	logic [6:0] len_s1;
	logic       idle_s1;
	byte_t      data_s1;
	byte_t      crc_pre_s1;

	// Output burst register.
	byte_t                byte_q [BURST_LEN];
	logic [BURST_LEN-1:0] end_q;
	logic [CNT_W-1:0]     cnt_q;

	logic in_acc, pop, burst_free, load;

	// Next-burst and next-state values.
	byte_t                ld_byte [BURST_LEN];
	logic [BURST_LEN-1:0] ld_end;
	logic [CNT_W-1:0]     ld_cnt;
	logic                 open_d;
	logic [6:0]           left_d, left_dec, len_sat;
	byte_t                crc_d, crc_hdr, crc_dat, crc_pre;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
			dest_q    <= '0;
			tail_hi_q <= '0;
			tail_lo_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STATION: station_q <= cfg_data;
				REG_DEST:    dest_q    <= cfg_data;
				REG_TAIL_HI: tail_hi_q <= cfg_data;
				REG_TAIL_LO: tail_lo_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Handshakes.
	assign out_valid  = (cnt_q != '0);
	assign pop        = out_valid && !out_stall;
	assign burst_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && !out_stall);
	assign load       = valid_s1 && burst_free;
	assign in_stall   = valid_s1 && !burst_free;
	assign in_acc     = in_valid && !in_stall;

	assign tx_byte   = byte_q[0];
	assign frame_end = end_q[0];

	// The destination and command part of the header CRC is settled on the way
	// in; configuration must not change while items are in flight, which the block does not enforce.
	assign crc_pre = crc8_update(crc8_update('0, dest_q), command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= op;
			cmd_s1     <= command;
			len_s1     <= payload_length;
			idle_s1    <= idle_header;
			data_s1    <= data_byte;
			crc_pre_s1 <= crc_pre;
		end
	end

	always_comb begin
		len_sat  = ({1'b0, len_s1} > MAX_PAY) ? MAX_PAY[6:0] : len_s1;
		crc_hdr  = crc8_update(crc8_update(crc_pre_s1, station_q), {1'b0, len_sat});
		crc_dat  = crc8_update(crc_q, data_s1);
		left_dec = (left_q != '0) ? (left_q - 7'd1) : left_q;

		for (int i = 0; i < BURST_LEN; i++) begin
			ld_byte[i] = '0;
		end
		ld_end = '0;
		ld_cnt = '0;
		open_d = open_q;
		left_d = left_q;
		crc_d  = crc_q;

		if (op_s1 == OP_BEGIN) begin
			ld_byte[0] = idle_s1 ? SOF0_IDLE : SOF0_NORMAL;
			ld_byte[1] = idle_s1 ? SOF1_IDLE : SOF1_NORMAL;
			ld_byte[2] = dest_q;
			ld_byte[3] = cmd_s1;
			ld_byte[4] = station_q;
			ld_byte[5] = {1'b0, len_sat};
			crc_d      = crc_hdr;
			open_d     = 1'b1;
			left_d     = len_sat;
			ld_cnt     = CNT_W'(6);
			if (len_sat == '0) begin
				ld_byte[6] = crc_hdr;
				ld_byte[7] = tail_hi_q;
				ld_byte[8] = tail_lo_q;
				ld_end[8]  = 1'b1;
				ld_cnt     = CNT_W'(9);
				open_d     = 1'b0;
			end
		end else if (open_q) begin
			ld_byte[0] = data_s1;
			crc_d      = crc_dat;
			left_d     = left_dec;
			ld_cnt     = CNT_W'(1);
			if (left_dec == '0) begin
				ld_byte[1] = crc_dat;
				ld_byte[2] = tail_hi_q;
				ld_byte[3] = tail_lo_q;
				ld_end[3]  = 1'b1;
				ld_cnt     = CNT_W'(4);
				open_d     = 1'b0;
			end
		end
		// A payload byte outside a frame loads an empty burst and is dropped.
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= '0;
			crc_q  <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			open_q <= open_d;
			left_q <= left_d;
			crc_q  <= crc_d;
			cnt_q  <= ld_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= ld_byte;
			end_q  <= ld_end;
		end else if (pop) begin
			for (int i = 0; i < BURST_LEN - 1; i++) begin
				byte_q[i] <= byte_q[i+1];
			end
			end_q <= {1'b0, end_q[BURST_LEN-1:1]};
		end
	end

endmodule

// ===== rtl/rsfb_checker.sv =====
// ----------------------------------------------------------------------------
// rsfb_checker
// Port-level checks for the frame builder, bound to its top level.
// ----------------------------------------------------------------------------
module rsfb_checker
	import rsfb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [7:0]           tx_byte,
	input logic                 frame_end
);

	// Set while the next output beat must open a new frame.
	logic expect_sof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_sof_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			expect_sof_q <= frame_end;
		end
	end

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(frame_end))
		else $error("result beat changed while stalled");

	// The input is only held off while a result burst is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	// After reset or a frame end, the next beat is a start byte.
	a_sof_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expect_sof_q |-> tx_byte == SOF0_NORMAL || tx_byte == SOF0_IDLE)
		else $error("frame did not open with a start byte");

	// The frame end is never marked on a start byte.
	a_end_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expect_sof_q |-> !frame_end)
		else $error("frame end marked on a start byte");

endmodule

bind rs485_frame_builder_crc8_top rsfb_checker u_rsfb_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// RS-485 frame builder testbench
// Drives begin and payload items with random gaps and checks every transmitted
// byte and its end mark against a model of the header, the CRC-8 and the tail.
// ----------------------------------------------------------------------------
package frame_check_pkg;
	import rsfb_pkg::*;

	localparam int MAX_PAYLOAD = BUF_BYTES_DEF - 9;

	typedef struct packed {
		byte_t tx;
		logic  last;
	} frame_beat_t;

	class frame_book;
		byte_t       station;
		byte_t       dest;
		byte_t       tail_hi;
		byte_t       tail_lo;
		bit          open;
		logic [6:0]  left;
		byte_t       crc;
		frame_beat_t due[$];
		int          errors;

		function new();
			station = '0;
			dest    = '0;
			tail_hi = '0;
			tail_lo = '0;
			open    = 1'b0;
			left    = '0;
			crc     = '0;
			errors  = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, byte_t v);
			case (idx)
				REG_STATION: station = v;
				REG_DEST:    dest    = v;
				REG_TAIL_HI: tail_hi = v;
				REG_TAIL_LO: tail_lo = v;
				default: ;
			endcase
		endfunction

		// Bit-serial form of the reflected CRC-8, data taken LSB first.
		function byte_t crc_mix(byte_t acc, byte_t d);
			byte_t c;
			bit    fb;
			c = acc;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ d[i];
				c  = c >> 1;
				if (fb) c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function void push(byte_t b, logic last);
			frame_beat_t e;
			e.tx   = b;
			e.last = last;
			due.push_back(e);
		endfunction

		function void close_frame();
			push(crc, 1'b0);
			push(tail_hi, 1'b0);
			push(tail_lo, 1'b1);
			open = 1'b0;
			left = '0;
		endfunction

		function void take_item(logic op_i, byte_t cmd, logic [6:0] len, logic idle,
				byte_t data);
			logic [6:0] n;
			if (op_i == OP_BEGIN) begin
				n = (len > MAX_PAYLOAD) ? 7'(MAX_PAYLOAD) : len;
				push(idle ? SOF0_IDLE : SOF0_NORMAL, 1'b0);
				push(idle ? SOF1_IDLE : SOF1_NORMAL, 1'b0);
				push(dest, 1'b0);
				push(cmd, 1'b0);
				push(station, 1'b0);
				push({1'b0, n}, 1'b0);
				crc  = crc_mix(crc_mix(crc_mix(crc_mix(8'h00, dest), cmd), station), {1'b0, n});
				open = 1'b1;
				left = n;
				if (n == 0) close_frame();
			end else if (open) begin
				push(data, 1'b0);
				crc = crc_mix(crc, data);
				if (left > 0) left = left - 7'd1;
				if (left == 0) close_frame();
			end
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function void check_beat(byte_t got_byte, logic got_end);
			frame_beat_t want;
			if (due.size() == 0) begin
				note_error($sformatf("unexpected beat: tx_byte=%02h frame_end=%0b",
					got_byte, got_end));
				return;
			end
			want = due.pop_front();
			if (got_byte !== want.tx || got_end !== want.last)
				note_error($sformatf("beat mismatch: tx_byte=%02h frame_end=%0b, expected %02h %0b",
					got_byte, got_end, want.tx, want.last));
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass
endpackage

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rsfb_pkg::*;
	import frame_check_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 16;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 op;
	logic [7:0]           command;
	logic [6:0]           payload_length;
	logic                 idle_header;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           tx_byte;
	logic                 frame_end;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	frame_book book = new();
	int        tx_max;
	int        rx_max;
	bit        hold_out;
	int        quiet_cycles;

	rs485_frame_builder_crc8_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.command        (command),
		.payload_length (payload_length),
		.idle_header    (idle_header),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tx_byte        (tx_byte),
		.frame_end      (frame_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Handshake monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				book.take_item(op, command, payload_length, idle_header, data_byte);
			if (out_valid && !out_stall)
				book.check_beat(tx_byte, frame_end);
			if (cfg_valid && cfg_ready)
				book.set_reg(cfg_index, cfg_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// Receiver: random stall before each beat, and one long hold-off on request.
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			if (hold_out) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			gap = $urandom_range(0, rx_max);
			repeat (gap) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(logic o, byte_t cmd, logic [6:0] len, logic idle, byte_t data);
		int gap;
		gap = $urandom_range(0, tx_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid       = 1'b1;
		op             = o;
		command        = cmd;
		payload_length = len;
		idle_header    = idle;
		data_byte      = data;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, byte_t v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sender goes quiet until every byte due has been seen, then lets the
	// pipeline settle in case the last item was a dropped payload byte.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_all_regs(byte_t st, byte_t de, byte_t th, byte_t tl);
		write_reg(REG_STATION, st);
		write_reg(REG_DEST, de);
		write_reg(REG_TAIL_HI, th);
		write_reg(REG_TAIL_LO, tl);
	endtask

	// Mostly complete frames with random content; some are cut short by a new
	// begin, and some are followed by stray payload bytes that must be dropped.
	task automatic random_phase(int n_items);
		int         sent;
		int         eff;
		int         k;
		logic [6:0] len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(8, 127))
				: 7'($urandom_range(0, 7));
			eff = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
			k   = eff;
			if (eff > 0 && $urandom_range(0, 7) == 0) k = $urandom_range(0, eff - 1);
			send_item(OP_BEGIN, 8'($urandom), len, 1'($urandom), 8'($urandom));
			repeat (k)
				send_item(OP_PAYLOAD, 8'($urandom), 7'($urandom), 1'($urandom),
					8'($urandom));
			sent += 1 + k;
			if (k == eff && $urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2))
					send_item(OP_PAYLOAD, 8'($urandom), 7'($urandom), 1'($urandom),
						8'($urandom));
			if ($urandom_range(0, 29) == 0) wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = OP_BEGIN;
		command        = '0;
		payload_length = '0;
		idle_header    = 1'b0;
		data_byte      = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_STATION;
		cfg_data       = '0;
		tx_max         = 0;
		rx_max         = 0;
		hold_out       = 1'b0;
		quiet_cycles   = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: stray byte after reset, then a header built from reset registers.
		tx_max = 2;
		rx_max = 2;
		send_item(OP_PAYLOAD, 8'h00, 7'd0, 1'b0, 8'hFF);
		send_item(OP_BEGIN, 8'h00, 7'd0, 1'b0, 8'h00);
		wait_idle();
		set_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);

		send_item(OP_BEGIN, 8'hFF, 7'd0, 1'b1, 8'hFF);
		send_item(OP_BEGIN, 8'hA5, 7'd2, 1'b0, 8'h00);
		send_item(OP_PAYLOAD, 8'h00, 7'd0, 1'b0, 8'h00);
		send_item(OP_PAYLOAD, 8'hFF, 7'd127, 1'b1, 8'hFF);
		send_item(OP_PAYLOAD, 8'h00, 7'd0, 1'b0, 8'h5A);
		// Over-long length saturates; the frame is then restarted by a new begin.
		send_item(OP_BEGIN, 8'h3C, 7'd127, 1'b1, 8'h00);
		send_item(OP_PAYLOAD, 8'h00, 7'd0, 1'b0, 8'h81);
		send_item(OP_BEGIN, 8'hC3, 7'd1, 1'b0, 8'h00);
		send_item(OP_PAYLOAD, 8'h00, 7'd0, 1'b0, 8'h7E);
		send_item(OP_BEGIN, 8'h55, 7'd119, 1'b0, 8'h00);
		send_item(OP_PAYLOAD, 8'h00, 7'd0, 1'b0, 8'h01);
		send_item(OP_BEGIN, 8'hAA, 7'd120, 1'b1, 8'h00);
		send_item(OP_BEGIN, 8'h80, 7'd0, 1'b0, 8'h00);
		wait_idle();

		// No idling, with the receiver held off long enough to back up the input.
		set_all_regs(8'h00, 8'h00, 8'h00, 8'h00);
		tx_max   = 0;
		rx_max   = 0;
		hold_out = 1'b1;
		random_phase(65);

		set_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		tx_max = 8;
		rx_max = 8;
		random_phase(65);

		set_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		tx_max = 8;
		rx_max = 0;
		random_phase(65);

		set_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		tx_max = 0;
		rx_max = 8;
		random_phase(65);

		if (book.errors == 0 && book.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rsfb_pkg.sv
rtl/rs485_frame_builder_crc8_top.sv
rtl/rsfb_checker.sv
tb/testbench.sv
